// ===== rtl/chacha20_stream_cipher_macros.svh =====
// Assertion macros for the stream cipher block.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
`define CC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/cc20_pkg.sv =====
// Shared types, constants and functions of the stream cipher block.
package cc20_pkg;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int RND_W = $clog2(2 * DOUBLE_ROUNDS + 1);
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam logic [2:0] REG_KEY01 = 3'd0;
    localparam logic [2:0] REG_KEY23 = 3'd1;
    localparam logic [2:0] REG_KEY45 = 3'd2;
    localparam logic [2:0] REG_KEY67 = 3'd3;
    localparam logic [2:0] REG_NONCE01 = 3'd4;
    localparam logic [2:0] REG_NONCE2 = 3'd5;
    localparam logic [2:0] REG_INITCTR = 3'd6;

    typedef struct packed {
        logic load;   // build input state and start rounds
        logic round;  // one half (column or diagonal) round
        logic fin;    // add input state back
    } cc_cmd_t;

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
        logic [31:0] a1, b1, c1, d1;
        a1 = a + b;   d1 = d ^ a1;  d1 = {d1[15:0], d1[31:16]};
        c1 = c + d1;  b1 = b ^ c1;  b1 = {b1[19:0], b1[31:20]};
        a1 = a1 + b1; d1 = d1 ^ a1; d1 = {d1[23:0], d1[31:24]};
        c1 = c1 + d1; b1 = b1 ^ c1; b1 = {b1[24:0], b1[31:25]};
        return {a1, b1, c1, d1};
    endfunction
endpackage

// ===== rtl/cc20_datapath.sv =====
// Block function datapath: state register, four quarter-round units, final add.
module cc20_datapath (
    input  logic             aclk,
    input  cc20_pkg::cc_cmd_t cmd,
    input  logic             diag,
    input  logic [511:0]     in_state,
    input  logic [3:0]       rd_idx,
    output logic [31:0]      ks_word
);
    import cc20_pkg::*;

    logic [31:0] x_reg [16];
    logic [31:0] x_next [16];
    logic [31:0] init_reg [16];
    logic [127:0] q [4];
    logic [31:0] in_w [16];

    always_comb begin
        for (int i = 0; i < 16; i++) in_w[i] = in_state[32*i +: 32];
        if (!diag) begin
            for (int i = 0; i < 4; i++) q[i] = qr(x_reg[i], x_reg[4+i], x_reg[8+i], x_reg[12+i]);
        end else begin
            q[0] = qr(x_reg[0], x_reg[5], x_reg[10], x_reg[15]);
            q[1] = qr(x_reg[1], x_reg[6], x_reg[11], x_reg[12]);
            q[2] = qr(x_reg[2], x_reg[7], x_reg[8], x_reg[13]);
            q[3] = qr(x_reg[3], x_reg[4], x_reg[9], x_reg[14]);
        end
        for (int i = 0; i < 16; i++) x_next[i] = x_reg[i];
        if (cmd.load) begin
            for (int i = 0; i < 16; i++) x_next[i] = in_w[i];
        end else if (cmd.round && !diag) begin
            for (int i = 0; i < 4; i++) begin
                x_next[i] = q[i][127:96]; x_next[4+i] = q[i][95:64];
                x_next[8+i] = q[i][63:32]; x_next[12+i] = q[i][31:0];
            end
        end else if (cmd.round) begin
            x_next[0] = q[0][127:96]; x_next[5] = q[0][95:64];
            x_next[10] = q[0][63:32]; x_next[15] = q[0][31:0];
            x_next[1] = q[1][127:96]; x_next[6] = q[1][95:64];
            x_next[11] = q[1][63:32]; x_next[12] = q[1][31:0];
            x_next[2] = q[2][127:96]; x_next[7] = q[2][95:64];
            x_next[8] = q[2][63:32]; x_next[13] = q[2][31:0];
            x_next[3] = q[3][127:96]; x_next[4] = q[3][95:64];
            x_next[9] = q[3][63:32]; x_next[14] = q[3][31:0];
        end else if (cmd.fin) begin
            for (int i = 0; i < 16; i++) x_next[i] = x_reg[i] + init_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) x_reg[i] <= x_next[i];
        if (cmd.load) begin
            for (int i = 0; i < 16; i++) init_reg[i] <= in_w[i];
        end
    end

    assign ks_word = x_reg[rd_idx];
endmodule

// ===== rtl/cc20_ctrl.sv =====
// Controller: handshakes, block counter, word position and round sequencing.
module cc20_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_last,
    input  logic [2:0]        in_bytes,
    input  logic [31:0]       in_word,
    input  logic [31:0]       init_ctr,
    input  logic [31:0]       ks_word,
    output logic [31:0]       ctr_out,
    output logic [3:0]        rd_idx,
    output cc20_pkg::cc_cmd_t cmd,
    output logic              diag,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_word,
    output logic              m_last,
    output logic [2:0]        m_bytes
);
    import cc20_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RND  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [RND_W-1:0] rnd_reg;
    logic [31:0] ctr_reg;
    logic [3:0] pos_reg;
    logic start_reg;
    logic [31:0] pt_reg;
    logic last_reg;
    logic [2:0] vb_reg;
    logic ov_reg;
    logic [2:0] vb_in;
    logic acc, out_free;
    logic [31:0] w;

    assign out_free = !ov_reg || m_tready;
    // a held result waits in ST_OUT, so the input side only needs the idle state
    assign s_tready = (state_reg == ST_IDLE);
    assign acc = s_tvalid && s_tready;
    assign vb_in = (in_bytes == 3'd0 || in_bytes > 3'd4) ? 3'd4 : in_bytes;
    assign ctr_out = start_reg ? init_ctr : ctr_reg;
    assign rd_idx = pos_reg;
    assign diag = rnd_reg[0];
    assign cmd.load = acc && pos_reg == 4'd0;
    assign cmd.round = state_reg == ST_RND;
    assign cmd.fin = state_reg == ST_FIN;
    assign w = (bswap(ks_word) ^ pt_reg) >> (6'd8 * (6'd4 - {3'd0, vb_reg}));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc) state_next = (pos_reg == 4'd0) ? ST_RND : ST_OUT;
            ST_RND: if (rnd_reg == RND_W'(2 * DOUBLE_ROUNDS - 1)) state_next = ST_FIN;
            ST_FIN: state_next = ST_OUT;
            ST_OUT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg <= '0;
            ctr_reg <= '0;
            pos_reg <= '0;
            start_reg <= 1'b1;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            if (cmd.load) begin
                ctr_reg <= ctr_out + 32'd1;
                start_reg <= 1'b0;
                rnd_reg <= '0;
            end
            if (cmd.round) rnd_reg <= rnd_reg + RND_W'(1);
            if (state_reg == ST_OUT && out_free) begin
                ov_reg <= 1'b1;
                if (last_reg) begin
                    pos_reg <= '0;
                    start_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            pt_reg <= in_word;
            last_reg <= in_last;
            vb_reg <= vb_in;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_word <= w;
            m_last <= last_reg;
            m_bytes <= vb_reg;
        end
    end

    assign m_tvalid = ov_reg;
endmodule

// ===== rtl/chacha20_stream_cipher.sv =====
// Top level of the ChaCha20 stream cipher block.
// Usage:
//  - s_ channel: one plaintext word per transfer, s_tdata[31:0] the word
//    (first byte in 31:24), s_tlast marks the final word, s_tuser holds
//    the count of valid bytes (1..4, other codes read as 4).
//  - m_ channel: one cipher word per input word, partial words right-aligned,
//    m_tlast copies the marker, m_tuser the byte count.
//  - cfg port: cfg_we, cfg_index, cfg_data load key, nonce and initial
//    counter; write only while idle.
// Sequencing: on the first word of each 64-byte block the block function runs
//  2*DOUBLE_ROUNDS half rounds on four quarter-round units, then the final add,
//  and that word's result is registered from the ST_OUT state; other words go
//  straight to ST_OUT. One word is in flight at a time: the next word is taken
//  only after the last one's result has left ST_OUT.
// Reset (aresetn low, synchronous) clears control and configuration registers,
//  position and counter; the next message starts from the initial counter.
// A stalled receiver holds the result in the output register; a new word
//  is taken, but its result waits until the register is free.
module chacha20_stream_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // plaintext_word
    input  logic        s_tlast,   // last_word
    input  logic [2:0]  s_tuser,   // valid_bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cipher_word
    output logic        m_tlast,   // result_last
    output logic [2:0]  m_tuser,   // result_bytes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import cc20_pkg::*;
    `include "chacha20_stream_cipher_macros.svh"

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    logic [31:0] nonce2_reg, ictr_reg;
    logic [31:0] ctr, ks_word;
    logic [3:0] rd_idx;
    logic diag;
    cc_cmd_t cmd;
    logic [511:0] in_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key01_reg <= '0; key23_reg <= '0; key45_reg <= '0; key67_reg <= '0;
            nonce01_reg <= '0; nonce2_reg <= '0; ictr_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY01:   key01_reg <= cfg_data;
                REG_KEY23:   key23_reg <= cfg_data;
                REG_KEY45:   key45_reg <= cfg_data;
                REG_KEY67:   key67_reg <= cfg_data;
                REG_NONCE01: nonce01_reg <= cfg_data;
                REG_NONCE2:  nonce2_reg <= cfg_data[31:0];
                REG_INITCTR: ictr_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // state word i sits in bits 32*i+31:32*i
    assign in_state = {bswap(nonce2_reg), bswap(nonce01_reg[31:0]), bswap(nonce01_reg[63:32]),
                       ctr,
                       bswap(key67_reg[31:0]), bswap(key67_reg[63:32]),
                       bswap(key45_reg[31:0]), bswap(key45_reg[63:32]),
                       bswap(key23_reg[31:0]), bswap(key23_reg[63:32]),
                       bswap(key01_reg[31:0]), bswap(key01_reg[63:32]),
                       SIGMA3, SIGMA2, SIGMA1, SIGMA0};

    cc20_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .in_last(s_tlast), .in_bytes(s_tuser), .in_word(s_tdata),
        .init_ctr(ictr_reg), .ks_word, .ctr_out(ctr), .rd_idx, .cmd, .diag,
        .m_tvalid, .m_tready, .m_word(m_tdata), .m_last(m_tlast), .m_bytes(m_tuser)
    );

    cc20_datapath u_dp (
        .aclk, .cmd, .diag, .in_state, .rd_idx, .ks_word
    );

    // only one command at a time
    `CC_ASSERT_IMP(a_cmd_onehot, aclk, aresetn, 1'b1, $onehot0(cmd))
    // no input taken while rounds run
    `CC_ASSERT_IMP(a_no_acc_rnd, aclk, aresetn, cmd.round, !s_tready)
    // a held result stays put under stall
    `CC_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

// ===== test/chacha20_stream_cipher_checker.sv =====
// Checker for the ChaCha20 stream cipher: predicts cipher words and compares them.
module chacha20_stream_cipher_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending_words
);
    import cc20_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic [2:0]  nbytes;
    } cipher_t;

    logic [63:0] key_pairs [4];
    logic [63:0] nonce01;
    logic [31:0] nonce2, init_ctr, blk_ctr;
    logic [31:0] keystream [16];
    logic [3:0]  pos;
    logic        new_msg;
    cipher_t     expected_ciphers [$];

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic quarter(inout logic [31:0] x [16], input int a, b, c, d);
        x[a] += x[b]; x[d] = rol(x[d] ^ x[a], 16);
        x[c] += x[d]; x[b] = rol(x[b] ^ x[c], 12);
        x[a] += x[b]; x[d] = rol(x[d] ^ x[a], 8);
        x[c] += x[d]; x[b] = rol(x[b] ^ x[c], 7);
    endtask

    task automatic build_keystream();
        logic [31:0] init [16];
        logic [31:0] x [16];
        init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = swap32(key_pairs[i][63:32]);
            init[5 + 2 * i] = swap32(key_pairs[i][31:0]);
        end
        init[12] = blk_ctr;
        init[13] = swap32(nonce01[63:32]);
        init[14] = swap32(nonce01[31:0]);
        init[15] = swap32(nonce2);
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            quarter(x, 0, 4, 8, 12);  quarter(x, 1, 5, 9, 13);
            quarter(x, 2, 6, 10, 14); quarter(x, 3, 7, 11, 15);
            quarter(x, 0, 5, 10, 15); quarter(x, 1, 6, 11, 12);
            quarter(x, 2, 7, 8, 13);  quarter(x, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) keystream[i] = x[i] + init[i];
        blk_ctr = blk_ctr + 32'd1;
    endtask

    task automatic encrypt_word(input logic [31:0] pt, input logic last, input logic [2:0] vb);
        cipher_t c;
        logic [2:0] n;
        n = (vb == 3'd0 || vb > 3'd4) ? 3'd4 : vb;
        if (pos == 4'd0) begin
            if (new_msg) begin
                blk_ctr = init_ctr;
                new_msg = 1'b0;
            end
            build_keystream();
        end
        c.word   = (swap32(keystream[pos]) ^ pt) >> (8 * (4 - n));
        c.last   = last;
        c.nbytes = n;
        expected_ciphers.push_back(c);
        pos = last ? 4'd0 : pos + 4'd1;
        if (last) new_msg = 1'b1;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_words = expected_ciphers.size();

    always @(posedge aclk) begin
        cipher_t e;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_pairs[i] = '0;
            nonce01 = '0; nonce2 = '0; init_ctr = '0; blk_ctr = '0;
            pos = '0; new_msg = 1'b1;
            expected_ciphers.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY01:   key_pairs[0] = cfg_data;
                    REG_KEY23:   key_pairs[1] = cfg_data;
                    REG_KEY45:   key_pairs[2] = cfg_data;
                    REG_KEY67:   key_pairs[3] = cfg_data;
                    REG_NONCE01: nonce01 = cfg_data;
                    REG_NONCE2:  nonce2 = cfg_data[31:0];
                    REG_INITCTR: init_ctr = cfg_data[31:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_ciphers.size() == 0) begin
                    report("unexpected transfer", m_tdata, '0);
                end else begin
                    e = expected_ciphers.pop_front();
                    if (m_tdata !== e.word) report("cipher word", m_tdata, e.word);
                    if (m_tlast !== e.last) report("last", 32'(m_tlast), 32'(e.last));
                    if (m_tuser !== e.nbytes)
                        report("byte count", 32'(m_tuser), 32'(e.nbytes));
                end
            end
            if (s_tvalid && s_tready) encrypt_word(s_tdata, s_tlast, s_tuser);
        end
    end
endmodule

// ===== test/chacha20_stream_cipher_tb.sv =====
// Testbench top for the ChaCha20 stream cipher: stimulus, receiver stalls and verdict.
module chacha20_stream_cipher_tb;
    import cc20_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0, s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [2:0]  s_tuser = 3'd4;
    logic        m_tvalid, m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          fail_count, pending_words;

    // Receiver modes: 0 random stalls, 1 always ready, 2 long hold-off
    int  rx_mode = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    chacha20_stream_cipher i_dut (.*);

    chacha20_stream_cipher_checker i_checker (.*);

    // Receiver: stall pattern of its own, switched by rx_mode
    always @(negedge aclk) begin
        case (rx_mode)
            1:       m_tready <= 1'b1;
            2:       m_tready <= 1'b0;
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offers one word and holds it until the transfer completes
    task automatic send_word(input logic [31:0] w, input logic last, input logic [2:0] vb);
        s_tvalid <= 1'b1; s_tdata <= w; s_tlast <= last; s_tuser <= vb;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    // Random message: mostly full words, tail of 1..4 bytes, occasionally odd byte codes
    task automatic send_message(input int nwords);
        logic [2:0] vb;
        int burst;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < nwords; i++) begin
            vb = 3'd4;
            if (i == nwords - 1) vb = 3'($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) vb = 3'($urandom_range(0, 7));
            send_word($urandom, i == nwords - 1, vb);
            if (--burst == 0) begin
                sender_gap();
                burst = $urandom_range(1, 12);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Drain all expected results, then allow the block to finish its latency
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic load_all(input logic [63:0] fill, input logic [31:0] ctr);
        write_reg(REG_KEY01, fill);
        write_reg(REG_KEY23, ~fill);
        write_reg(REG_KEY45, {fill[31:0], fill[63:32]});
        write_reg(REG_KEY67, fill ^ 64'h0123_4567_89ab_cdef);
        write_reg(REG_NONCE01, ~fill);
        write_reg(REG_NONCE2, {32'h0, fill[31:0]});
        write_reg(REG_INITCTR, {32'h0, ctr});
    endtask

    initial begin
        int sent;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset key, all-zero and all-one data, every byte count
        rx_mode = 1;
        send_word(32'h0000_0000, 1'b0, 3'd4);
        send_word(32'hffff_ffff, 1'b0, 3'd4);
        send_word(32'ha5a5_5a5a, 1'b0, 3'd1); // partial word not marked last
        send_word(32'h1234_5678, 1'b0, 3'd0); // out-of-range code reads as four
        send_word(32'hdead_beef, 1'b0, 3'd7);
        send_word(32'hcafe_f00d, 1'b0, 3'd5);
        send_word(32'h8000_0001, 1'b0, 3'd2);
        send_word(32'h7fff_fffe, 1'b1, 3'd3);  // last word resets position
        send_word(32'hffff_ffff, 1'b1, 3'd4);  // single-word message
        drain();

        // Extreme settings, counter about to wrap, message over two blocks
        load_all(64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 17; i++) send_word($urandom, i == 16, 3'd4);
        drain();
        write_reg(3'd7, 64'h1111_2222_3333_4444); // unknown index, ignored

        // Random phases with different settings
        rx_mode = 0;
        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 1) load_all('0, '0);
            else load_all({$urandom, $urandom}, phase == 3 ? 32'hffff_fffe : $urandom);
            rx_mode = (phase == 4) ? 1 : 0;
            for (int m = 0; m < 8; m++) begin
                int n;
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(10, 40);
                send_message(n);
                sent += n;
            end
            drain();
        end

        // Receiver holds off for a long stretch while words keep coming
        fork
            begin
                rx_mode = 2;
                repeat (300) @(negedge aclk);
                rx_mode = 0;
            end
            send_message(40);
        join
        drain();

        while (sent < 1300) begin
            int n;
            n = $urandom_range(1, 48);
            send_message(n);
            sent += n;
        end
        drain();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== chacha20_stream_cipher.f =====
+incdir+rtl
rtl/cc20_pkg.sv
rtl/cc20_datapath.sv
rtl/cc20_ctrl.sv
rtl/chacha20_stream_cipher.sv
test/chacha20_stream_cipher_checker.sv
test/chacha20_stream_cipher_tb.sv
